// ----- hdl/kwlex_pkg.sv -----
// Package with the token kinds, the keyword table and the character classifiers of the lexer.
package kwlex_pkg;

    localparam int KIND_W      = 5;
    localparam int LINE_W      = 32;
    localparam int OFFS_W      = 32;
    localparam int LEN_W       = 16;
    localparam int CHAR_W      = 8;
    localparam int NUM_KW      = 12;
    localparam int KW_TEXT_MAX = 8;
    localparam int RES_DEPTH   = 4;
    localparam int RES_PTR_W   = $clog2(RES_DEPTH);
    localparam int RES_FILL_W  = $clog2(RES_DEPTH + 1);

    localparam logic [KIND_W-1:0] KIND_IDENT    = 5'd0;
    localparam logic [KIND_W-1:0] KIND_NUMBER   = 5'd1;
    localparam logic [KIND_W-1:0] KIND_KEYWORD0 = 5'd2;
    localparam logic [KIND_W-1:0] KIND_PLUS     = 5'd14;
    localparam logic [KIND_W-1:0] KIND_MINUS    = 5'd15;
    localparam logic [KIND_W-1:0] KIND_STAR     = 5'd16;
    localparam logic [KIND_W-1:0] KIND_SLASH    = 5'd17;
    localparam logic [KIND_W-1:0] KIND_ASSIGN   = 5'd18;
    localparam logic [KIND_W-1:0] KIND_SEMI     = 5'd19;
    localparam logic [KIND_W-1:0] KIND_LPAREN   = 5'd20;
    localparam logic [KIND_W-1:0] KIND_RPAREN   = 5'd21;
    localparam logic [KIND_W-1:0] KIND_LBRACE   = 5'd22;
    localparam logic [KIND_W-1:0] KIND_RBRACE   = 5'd23;
    localparam logic [KIND_W-1:0] KIND_COMMA    = 5'd24;
    localparam logic [KIND_W-1:0] KIND_UNKNOWN  = 5'd25;

    // Keyword text is right-justified: the last character sits in the lowest byte.
    localparam logic [8*KW_TEXT_MAX-1:0] KW_TEXT [NUM_KW] = '{
        "if", "else", "for", "while", "return", "true",
        "false", "print", "break", "continue", "void", "fun"
    };
    localparam int KW_LEN [NUM_KW] = '{2, 4, 3, 5, 6, 4, 5, 5, 5, 8, 4, 3};

    typedef logic [KW_TEXT_MAX-1:0][CHAR_W-1:0] t_kw_buf;

    typedef struct packed {
        logic [LEN_W-1:0]  length;
        logic [OFFS_W-1:0] start;
        logic [LINE_W-1:0] line;
        logic [KIND_W-1:0] kind;
        logic              last;
    } t_token;

    typedef struct packed {
        logic [RES_FILL_W-1:0] fill;
        logic                  room2;
    } t_res_stat;

    function automatic logic is_alpha(input logic [CHAR_W-1:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_space(input logic [CHAR_W-1:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic [KIND_W-1:0] punct_kind(input logic [CHAR_W-1:0] c);
        logic [KIND_W-1:0] k;
        case (c)
            8'h2B:   k = KIND_PLUS;
            8'h2D:   k = KIND_MINUS;
            8'h2A:   k = KIND_STAR;
            8'h2F:   k = KIND_SLASH;
            8'h3D:   k = KIND_ASSIGN;
            8'h3B:   k = KIND_SEMI;
            8'h28:   k = KIND_LPAREN;
            8'h29:   k = KIND_RPAREN;
            8'h7B:   k = KIND_LBRACE;
            8'h7D:   k = KIND_RBRACE;
            8'h2C:   k = KIND_COMMA;
            default: k = KIND_UNKNOWN;
        endcase
        return k;
    endfunction

    // An identifier is a keyword only if its length equals the keyword's length.
    function automatic logic [KIND_W-1:0] kw_kind(input t_kw_buf buf_text,
                                                   input logic [LEN_W-1:0] cnt);
        logic [KIND_W-1:0] kind;
        logic              hit;
        kind = KIND_IDENT;
        for (int k = 0; k < NUM_KW; k++) begin
            hit = (cnt == LEN_W'(KW_LEN[k]));
            for (int i = 0; i < KW_TEXT_MAX; i++) begin
                if (i < KW_LEN[k]) begin
                    hit = hit && (buf_text[i] == KW_TEXT[k][8*(KW_LEN[k]-1-i) +: 8]);
                end
            end
            if (hit) begin
                kind = KIND_KEYWORD0 + KIND_W'(k);
            end
        end
        return kind;
    endfunction

endpackage

// ----- hdl/kwlex_res_fifo.sv -----
// Result queue that takes up to two tokens per cycle and hands out one per cycle while the reader is ready.
module kwlex_res_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [1:0]          i_wr_cnt,
    input  kwlex_pkg::t_token   i_wr_data0,
    input  kwlex_pkg::t_token   i_wr_data1,
    output logic                o_rd_valid,
    input  logic                i_rd_ready,
    output kwlex_pkg::t_token   o_rd_data,
    output kwlex_pkg::t_res_stat o_stat
);

    kwlex_pkg::t_token r_mem [kwlex_pkg::RES_DEPTH];
    logic [kwlex_pkg::RES_PTR_W-1:0]  r_wr;
    logic [kwlex_pkg::RES_PTR_W-1:0]  r_rd;
    logic [kwlex_pkg::RES_FILL_W-1:0] r_fill;
    logic [kwlex_pkg::RES_PTR_W-1:0]  wr_next;
    logic                             pop;

    assign wr_next    = r_wr + 1'b1;
    assign pop        = o_rd_valid && i_rd_ready;
    assign o_rd_valid = (r_fill != '0);
    assign o_rd_data  = r_mem[r_rd];
    assign o_stat.fill  = r_fill;
    assign o_stat.room2 = (r_fill <= kwlex_pkg::RES_FILL_W'(kwlex_pkg::RES_DEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (i_wr_cnt != 2'd0) begin
            r_mem[r_wr] <= i_wr_data0;
        end
        if (i_wr_cnt == 2'd2) begin
            r_mem[wr_next] <= i_wr_data1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            r_wr   <= r_wr + kwlex_pkg::RES_PTR_W'(i_wr_cnt);
            r_rd   <= r_rd + kwlex_pkg::RES_PTR_W'(pop);
            r_fill <= r_fill + kwlex_pkg::RES_FILL_W'(i_wr_cnt)
                      - kwlex_pkg::RES_FILL_W'(pop);
        end
    end

endmodule

// ----- hdl/keyword_lexer.sv -----
// Top level of the streaming lexer: scanner state, token forming and the result queue.
// The lexer takes one source byte per cycle: classification, keyword matching and token
// forming sit between the scanner registers and a four-entry result queue. A byte is
// taken while the queue has room for two tokens, so a byte that ends one token and yields
// another, or a consumer that stalls, can slow the input.
// Each token carries kind, line, start offset and length; the text itself is not sent.
// Setting tlast on a byte marks the end of the text: pending tokens are flushed and the
// lexer returns to its reset state, with offsets counted from zero and lines from one.
module keyword_lexer #(
    parameter int KEYWORD_MAX_LEN = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // char_byte
    input  logic        i_s_tlast,   // end_of_input
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [87:0] o_m_tdata,   // token_kind, line_number, start_offset, token_length, pad
    output logic        o_m_tlast    // last_of_run
);

    localparam int IDX_W = $clog2(KEYWORD_MAX_LEN);
    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_IDENT  = 2'd1;
    localparam logic [1:0] MODE_NUMBER = 2'd2;
    localparam logic [kwlex_pkg::LEN_W-1:0]  LEN_MAX  = '1;
    localparam logic [kwlex_pkg::LINE_W-1:0] LINE_MAX = '1;

    logic [1:0]                          r_mode, n_mode;
    logic [KEYWORD_MAX_LEN-1:0][7:0]     r_kbuf, n_kbuf;
    logic [kwlex_pkg::OFFS_W-1:0]        r_start, n_start;
    logic [kwlex_pkg::LEN_W-1:0]         r_count, n_count;
    logic [kwlex_pkg::OFFS_W-1:0]        r_pos, n_pos;
    logic [kwlex_pkg::LINE_W-1:0]        r_line, n_line;

    logic                       accept;
    logic [7:0]                 c;
    logic                       eoi;
    logic                       c_alpha, c_digit, c_space, c_word;
    logic                       cont, start_tok;
    logic [kwlex_pkg::LEN_W-1:0] cnt_inc;
    kwlex_pkg::t_kw_buf         fl_buf;
    logic [kwlex_pkg::LEN_W-1:0] fl_cnt;
    logic                       res_a_vld, res_b_vld;
    kwlex_pkg::t_token          res_a, res_b, wr0;
    logic [1:0]                 wr_cnt;
    kwlex_pkg::t_token          out_tok;
    kwlex_pkg::t_res_stat       q_stat;

    assign c       = i_s_tdata;
    assign eoi     = i_s_tlast;
    assign accept  = i_s_tvalid && o_s_tready;
    assign c_alpha = kwlex_pkg::is_alpha(c) || (c == 8'h5F);
    assign c_digit = kwlex_pkg::is_digit(c);
    assign c_space = kwlex_pkg::is_space(c);
    assign c_word  = c_alpha || c_digit;

    assign cont      = (r_mode == MODE_IDENT && c_word) || (r_mode == MODE_NUMBER && c_digit);
    assign start_tok = !cont && c_word;
    assign cnt_inc   = (r_count == LEN_MAX) ? r_count : r_count + 1'b1;

    always_comb begin
        n_kbuf = r_kbuf;
        if (start_tok) begin
            n_kbuf    = '0;
            n_kbuf[0] = c;
        end else if (cont && r_count < kwlex_pkg::LEN_W'(KEYWORD_MAX_LEN)) begin
            n_kbuf[r_count[IDX_W-1:0]] = c;
        end
    end

    assign fl_buf = cont ? kwlex_pkg::t_kw_buf'(n_kbuf[kwlex_pkg::KW_TEXT_MAX-1:0])
                         : kwlex_pkg::t_kw_buf'(r_kbuf[kwlex_pkg::KW_TEXT_MAX-1:0]);
    assign fl_cnt = cont ? cnt_inc : r_count;

    // The pending token goes out first; the byte's own token, if any, follows it.
    assign res_a_vld = accept && (cont ? eoi : (r_mode != MODE_IDLE));
    assign res_b_vld = accept && !cont && !c_space && (!c_word || eoi);

    always_comb begin
        res_a.kind   = (r_mode == MODE_IDENT) ? kwlex_pkg::kw_kind(fl_buf, fl_cnt)
                                              : kwlex_pkg::KIND_NUMBER;
        res_a.line   = r_line;
        res_a.start  = r_start;
        res_a.length = fl_cnt;
        res_a.last   = !res_b_vld;

        // No keyword is one character long, so a lone letter is always an identifier.
        if (c_alpha) begin
            res_b.kind = kwlex_pkg::KIND_IDENT;
        end else if (c_digit) begin
            res_b.kind = kwlex_pkg::KIND_NUMBER;
        end else begin
            res_b.kind = kwlex_pkg::punct_kind(c);
        end
        res_b.line   = r_line;
        res_b.start  = r_pos;
        res_b.length = kwlex_pkg::LEN_W'(1);
        res_b.last   = 1'b1;
    end

    assign wr0    = res_a_vld ? res_a : res_b;
    assign wr_cnt = 2'(res_a_vld) + 2'(res_b_vld);

    always_comb begin
        n_mode  = r_mode;
        n_start = r_start;
        n_count = r_count;
        n_pos   = r_pos + 1'b1;
        n_line  = r_line;
        if (cont) begin
            n_count = cnt_inc;
        end else if (c_alpha) begin
            n_mode  = MODE_IDENT;
            n_start = r_pos;
            n_count = kwlex_pkg::LEN_W'(1);
        end else if (c_digit) begin
            n_mode  = MODE_NUMBER;
            n_start = r_pos;
            n_count = kwlex_pkg::LEN_W'(1);
        end else begin
            n_mode = MODE_IDLE;
            if (c == 8'h0A && r_line != LINE_MAX) begin
                n_line = r_line + 1'b1;
            end
        end
        if (eoi) begin
            n_mode  = MODE_IDLE;
            n_start = '0;
            n_count = '0;
            n_pos   = '0;
            n_line  = kwlex_pkg::LINE_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_start <= '0;
            r_count <= '0;
            r_pos   <= '0;
            r_line  <= kwlex_pkg::LINE_W'(1);
        end else if (accept) begin
            r_mode  <= n_mode;
            r_start <= n_start;
            r_count <= n_count;
            r_pos   <= n_pos;
            r_line  <= n_line;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kbuf <= n_kbuf;
        end
    end

    kwlex_res_fifo u_res_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_cnt   (wr_cnt),
        .i_wr_data0 (wr0),
        .i_wr_data1 (res_b),
        .o_rd_valid (o_m_tvalid),
        .i_rd_ready (i_m_tready),
        .o_rd_data  (out_tok),
        .o_stat     (q_stat)
    );

    assign o_s_tready = q_stat.room2;
    assign o_m_tdata  = {3'b000, out_tok.length, out_tok.start, out_tok.line, out_tok.kind};
    assign o_m_tlast  = out_tok.last;

    a_line_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line != '0)
        else $error("line counter reached zero");

    a_ready_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> q_stat.fill <= kwlex_pkg::RES_FILL_W'(kwlex_pkg::RES_DEPTH - 2))
        else $error("input taken without room for two tokens");

    a_ident_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_IDENT || r_mode == MODE_NUMBER) |-> r_count != '0)
        else $error("pending token has zero length");

    a_eoi_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && eoi) |=> (r_pos == '0 && r_mode == MODE_IDLE
                             && r_line == kwlex_pkg::LINE_W'(1)))
        else $error("end of text did not restore the reset state");

endmodule
